>>> hw/rtl/bbd_pkg.sv
package bbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 13;
    localparam int DIM_W      = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS    = 2'd3;

    localparam logic [2:0] PAT_GRAY = 3'd0;
    localparam logic [2:0] PAT_RGGB = 3'd1;
    localparam logic [2:0] PAT_BGGR = 3'd2;
    localparam logic [2:0] PAT_GRBG = 3'd3;
    localparam logic [2:0] PAT_GBRG = 3'd4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] raw_sample;
    } sample_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } pixel_t;

    // one column of the 3x3 window, rows above, at and below the centre
    typedef struct packed {
        logic [7:0] t;
        logic [7:0] m;
        logic [7:0] b;
    } column_t;

    typedef struct packed {
        logic       clamp_top;
        logic       clamp_bot;
        logic       px_odd;
        logic       py_odd;
        logic [2:0] pattern;
        logic       last;
    } interp_ctl_t;

endpackage

>>> hw/rtl/bayer_bilinear_demosaic.sv
// A pixel passes the s1 and output registers after the sample completing its
// window, which comes one row plus one pixel after its own sample. Throughput:
// one beat per cycle while pixel_stall is low, set by one line-memory read
// and one write per sample; in a one-row frame the first flush beat raises
// sample_stall. Reset clears control, window, registers (640x480, gray, 8 bits).
module bayer_bilinear_demosaic
    import bbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output pixel_t               pixel,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [2:0]       pattern_reg;
    logic [5:0]       sample_bits_reg;

    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic             again_reg;

    logic             s1_valid_reg;
    logic             s1_real_reg;
    logic             s1_emit_reg;
    logic [COL_W-1:0] s1_x_reg;
    logic             s1_x0_reg;
    logic             s1_x1_reg;
    interp_ctl_t      s1_ctl_reg;
    logic [7:0]       s1_sample_reg;
    logic             s1_fwd_reg;
    logic [7:0]       fwd_a_reg;
    logic [7:0]       fwd_b_reg;

    column_t          p1_reg;
    column_t          p2_reg;

    logic             out_valid_reg;
    pixel_t           out_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             en;
    logic             accept;
    logic             step;
    logic             real0;
    logic             virt0;
    logic             x0;
    logic             emit0;
    logic             last0;
    logic [ROW_W-1:0] r0;
    logic [DIM_W:0]   x_inc;
    logic [7:0]       scaled;
    logic [5:0]       sh;
    logic [31:0]      shr;
    logic [39:0]      shl;
    interp_ctl_t      ctl0;

    logic [7:0]       a_rd;
    logic [7:0]       b_rd;
    logic [7:0]       a_eff;
    logic [7:0]       b_eff;
    column_t          v_col;
    column_t          l_col;
    column_t          r_col;
    pixel_t           pix;
    logic             w_is1;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    assign w_is1 = (w_eff == DIM_W'(1));

    // scale to 8 bits
    always_comb
    begin
        shr = '0;
        shl = '0;
        sh  = '0;
        if (sample_bits_reg > 6'd8)
        begin
            sh  = sample_bits_reg - 6'd8;
            shr = sample.raw_sample >> sh[4:0];
            scaled = (sh >= 6'd32) ? 8'd0 : shr[7:0];
        end
        else
        begin
            shl    = {8'd0, sample.raw_sample} << (6'd8 - sample_bits_reg);
            scaled = shl[7:0];
        end
    end

    assign en           = !out_valid_reg || !pixel_stall;
    assign sample_stall = !en || again_reg;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        virt0 = ({1'b0, y_reg} >= {1'b0, h_eff});
        real0 = !virt0 && !again_reg && accept && !sample.kind;
        step  = again_reg ? en : (accept && (virt0 || !sample.kind));
        x0    = (x_reg == '0);
        emit0 = (y_reg >= ROW_W'(2)) || ((y_reg == ROW_W'(1)) && !x0);
        last0 = virt0 && x0 && ({1'b0, y_reg} == ({1'b0, h_eff} + 14'd1));
        r0    = y_reg - (x0 ? ROW_W'(2) : ROW_W'(1));
        x_inc = {2'b00, x_reg} + 14'd1;

        ctl0.clamp_top = (r0 == '0);
        ctl0.clamp_bot = (r0 == (h_eff - DIM_W'(1)));
        ctl0.px_odd    = x0 ? ~w_eff[0] : ~x_reg[0];
        ctl0.py_odd    = r0[0];
        ctl0.pattern   = pattern_reg;
        ctl0.last      = last0;

        x_next = x_reg;
        y_next = y_reg;
        if (step)
        begin
            if (last0)
            begin
                x_next = '0;
                y_next = '0;
            end
            else if (x_inc >= {1'b0, w_eff})
            begin
                x_next = '0;
                y_next = y_reg + ROW_W'(1);
            end
            else
            begin
                x_next = x_inc[COL_W-1:0];
            end
        end
    end

    bbd_line_mem u_mem (
        .clk     (clk),
        .rd_en   (step),
        .rd_addr (x_reg),
        .wr_en   (en && s1_valid_reg && s1_real_reg),
        .wr_addr (s1_x_reg),
        .wr_a    (s1_sample_reg),
        .wr_b    (a_eff),
        .rd_a    (a_rd),
        .rd_b    (b_rd)
    );

    always_comb
    begin
        a_eff     = s1_fwd_reg ? fwd_a_reg : a_rd;
        b_eff     = s1_fwd_reg ? fwd_b_reg : b_rd;
        v_col.t   = b_eff;
        v_col.m   = a_eff;
        v_col.b   = s1_real_reg ? s1_sample_reg : a_eff;
        if (s1_x0_reg)
        begin
            l_col = w_is1 ? p1_reg : p2_reg;
            r_col = p1_reg;
        end
        else
        begin
            l_col = s1_x1_reg ? p1_reg : p2_reg;
            r_col = v_col;
        end
    end

    bbd_interp u_interp (
        .left   (l_col),
        .centre (p1_reg),
        .right  (r_col),
        .ctl    (s1_ctl_reg),
        .pix    (pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            pattern_reg      <= PAT_GRAY;
            sample_bits_reg  <= 6'd8;
            x_reg            <= '0;
            y_reg            <= '0;
            again_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_real_reg      <= 1'b0;
            s1_fwd_reg       <= 1'b0;
            p1_reg           <= '0;
            p2_reg           <= '0;
            out_valid_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            // any write drops the frame in progress
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_MOSAIC_PATTERN: pattern_reg      <= cfg_data[2:0];
                REG_SAMPLE_BITS:    sample_bits_reg  <= cfg_data[5:0];
                default:            pattern_reg      <= pattern_reg;
            endcase
            x_reg     <= '0;
            y_reg     <= '0;
            again_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (en)
            begin
                again_reg    <= step && virt0 && !emit0;
                s1_valid_reg <= step;
                s1_real_reg  <= real0;
                // same column written by the beat ahead: memory still holds old data
                s1_fwd_reg   <= s1_valid_reg && s1_real_reg && (s1_x_reg == x_reg);
                if (s1_valid_reg)
                begin
                    p2_reg <= p1_reg;
                    p1_reg <= v_col;
                end
                out_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg   <= emit0;
            s1_x_reg      <= x_reg;
            s1_x0_reg     <= x0;
            s1_x1_reg     <= (x_reg == COL_W'(1));
            s1_ctl_reg    <= ctl0;
            s1_sample_reg <= scaled;
            fwd_a_reg     <= s1_sample_reg;
            fwd_b_reg     <= a_eff;
            out_reg       <= pix;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

>>> hw/rtl/bbd_line_mem.sv
module bbd_line_mem
    import bbd_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [7:0]       wr_a,
    input  logic [7:0]       wr_b,
    output logic [7:0]       rd_a,
    output logic [7:0]       rd_b
);

    logic [7:0] mem_a [MAX_WIDTH];
    logic [7:0] mem_b [MAX_WIDTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem_a[rd_addr];
            rd_b_reg <= mem_b[rd_addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> hw/rtl/bbd_interp.sv
module bbd_interp
    import bbd_pkg::*;
(
    input  column_t     left,
    input  column_t     centre,
    input  column_t     right,
    input  interp_ctl_t ctl,
    output pixel_t      pix
);

    column_t    l_c;
    column_t    c_c;
    column_t    r_c;
    logic [8:0] hor;
    logic [8:0] ver;
    logic [9:0] cross_sum;
    logic [9:0] diag_sum;
    logic [7:0] cross_avg;
    logic [7:0] diag;
    logic       rx;
    logic       ry;
    logic       colour;
    logic       r_col;
    logic       r_row;

    function automatic column_t clamp_col(column_t c, logic top, logic bot);
        column_t o;
        o.t = top ? c.m : c.t;
        o.m = c.m;
        o.b = bot ? c.m : c.b;
        return o;
    endfunction

    always_comb
    begin
        l_c = clamp_col(left, ctl.clamp_top, ctl.clamp_bot);
        c_c = clamp_col(centre, ctl.clamp_top, ctl.clamp_bot);
        r_c = clamp_col(right, ctl.clamp_top, ctl.clamp_bot);

        hor       = {1'b0, l_c.m} + {1'b0, r_c.m};
        ver       = {1'b0, c_c.t} + {1'b0, c_c.b};
        cross_sum = {1'b0, hor} + {1'b0, ver};
        diag_sum  = {2'b00, l_c.t} + {2'b00, r_c.t} + {2'b00, l_c.b} + {2'b00, r_c.b};
        cross_avg = cross_sum[9:2];
        diag      = diag_sum[9:2];

        colour = 1'b1;
        rx     = 1'b0;
        ry     = 1'b0;
        case (ctl.pattern)
            PAT_RGGB:
            begin
                rx = 1'b0; ry = 1'b0;
            end
            PAT_BGGR:
            begin
                rx = 1'b1; ry = 1'b1;
            end
            PAT_GRBG:
            begin
                rx = 1'b1; ry = 1'b0;
            end
            PAT_GBRG:
            begin
                rx = 1'b0; ry = 1'b1;
            end
            default:
            begin
                colour = 1'b0;
            end
        endcase

        r_col = (ctl.px_odd == rx);
        r_row = (ctl.py_odd == ry);

        pix.red       = c_c.m;
        pix.green     = c_c.m;
        pix.blue      = c_c.m;
        pix.alpha     = ALPHA_OPAQUE;
        pix.frame_end = ctl.last;
        if (colour)
        begin
            if (r_col && r_row)
            begin
                pix.green = cross_avg;
                pix.blue  = diag;
            end
            else if (!r_col && !r_row)
            begin
                pix.green = cross_avg;
                pix.red   = diag;
            end
            else if (r_row)
            begin
                pix.red  = hor[8:1];
                pix.blue = ver[8:1];
            end
            else
            begin
                pix.red  = ver[8:1];
                pix.blue = hor[8:1];
            end
        end
    end

endmodule

>>> tb/bayer_bilinear_demosaic_tb.sv
`timescale 1ns / 1ps

module bayer_bilinear_demosaic_tb;
    import bbd_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample = '0;
    logic                 pixel_valid;
    logic                 pixel_stall = 1'b0;
    pixel_t               pixel;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    bayer_bilinear_demosaic u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the block: registers, line stores, eviction window, counters
    int unsigned     sh_width = 640;
    int unsigned     sh_height = 480;
    int unsigned     sh_pattern = 0;
    int unsigned     sh_bits = 8;
    logic [7:0]      row_a [MAX_WIDTH];
    logic [7:0]      row_b [MAX_WIDTH];
    logic [7:0]      evicted [3];
    int unsigned     in_col = 0;
    int unsigned     in_row = 0;
    int unsigned     pix_count = 0;

    pixel_t          pending_pixels [$];
    bit              frame_done;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              errors = 0;
    int              beats_sent = 0;
    int              pixels_seen = 0;
    int              frames_done = 0;
    longint          cycle_count = 0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1)
            return 1;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return v;
    endfunction

    function automatic logic [7:0] scale_raw(logic [31:0] v);
        logic [31:0] t;
        if (sh_bits > 8)
        begin
            if (sh_bits - 8 >= 32)
                return 8'd0;
            t = v >> (sh_bits - 8);
        end
        else
            t = v << (8 - sh_bits);
        return t[7:0];
    endfunction

    function automatic int unsigned fetch_raster(int unsigned i, int unsigned latest,
                                                 int unsigned w);
        int unsigned d;
        int unsigned cx;
        if (i > latest)
            return 0;
        d  = latest - i;
        cx = i % w;
        if (d < w)
            return row_a[cx];
        if (d < 2 * w)
            return row_b[cx];
        d = d - 2 * w;
        if (d < 3)
            return evicted[d];
        return 0;
    endfunction

    // edge-replicated neighbour at offset (dx, dy)
    function automatic int unsigned nb(int unsigned px, int unsigned py, int dx, int dy,
                                       int unsigned w, int unsigned h,
                                       int unsigned latest);
        int unsigned cx;
        int unsigned cy;
        cx = px;
        cy = py;
        if (dx < 0 && cx > 0)
            cx--;
        else if (dx > 0 && cx + 1 < w)
            cx++;
        if (dy < 0 && cy > 0)
            cy--;
        else if (dy > 0 && cy + 1 < h)
            cy++;
        return fetch_raster(cy * w + cx, latest, w);
    endfunction

    function automatic pixel_t interpolate(int unsigned p, int unsigned w, int unsigned h,
                                           int unsigned latest);
        int unsigned px, py, c, r, g, b, rx, ry, hor, ver, cross_avg, diag;
        bit          r_col, r_row;
        pixel_t      o;
        px = p % w;
        py = p / w;
        c  = nb(px, py, 0, 0, w, h, latest);
        r  = c;
        g  = c;
        b  = c;
        rx = 2;
        ry = 2;
        case (sh_pattern[2:0])
            PAT_RGGB: begin rx = 0; ry = 0; end
            PAT_BGGR: begin rx = 1; ry = 1; end
            PAT_GRBG: begin rx = 1; ry = 0; end
            PAT_GBRG: begin rx = 0; ry = 1; end
            default:  ;
        endcase
        if (rx < 2)
        begin
            hor       = nb(px, py, -1, 0, w, h, latest) + nb(px, py, 1, 0, w, h, latest);
            ver       = nb(px, py, 0, -1, w, h, latest) + nb(px, py, 0, 1, w, h, latest);
            cross_avg = (hor + ver) / 4;
            diag  = (nb(px, py, -1, -1, w, h, latest) + nb(px, py, 1, -1, w, h, latest) +
                     nb(px, py, -1, 1, w, h, latest) + nb(px, py, 1, 1, w, h, latest)) / 4;
            r_col = ((px ^ rx) & 1) == 0;
            r_row = ((py ^ ry) & 1) == 0;
            if (r_col && r_row)
            begin
                g = cross_avg;
                b = diag;
            end
            else if (!r_col && !r_row)
            begin
                g = cross_avg;
                r = diag;
            end
            else if (r_row)
            begin
                r = hor / 2;
                b = ver / 2;
            end
            else
            begin
                r = ver / 2;
                b = hor / 2;
            end
        end
        o.red       = r[7:0];
        o.green     = g[7:0];
        o.blue      = b[7:0];
        o.alpha     = ALPHA_OPAQUE;
        o.frame_end = 1'b0;
        return o;
    endfunction

    task automatic demosaic_step(sample_t s);
        int unsigned w, h, written;
        bit          emit;
        pixel_t      o;
        w    = clamp_dim(sh_width);
        h    = clamp_dim(sh_height);
        emit = 1'b0;
        if (s.kind == 1'b0 && in_row < h && in_col < w)
        begin
            evicted[2]     = evicted[1];
            evicted[1]     = evicted[0];
            evicted[0]     = row_b[in_col];
            row_b[in_col]  = row_a[in_col];
            row_a[in_col]  = scale_raw(s.raw_sample);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            written = in_row * w + in_col;
            emit = (pix_count + w + 2 <= written);
        end
        else
        begin
            if (in_row < h)
                return;
            written = w * h;
            emit = (pix_count < w * h);
        end
        if (!emit || written == 0)
            return;
        o = interpolate(pix_count, w, h, written - 1);
        pix_count++;
        if (pix_count >= w * h)
        begin
            o.frame_end = 1'b1;
            in_col      = 0;
            in_row      = 0;
            pix_count   = 0;
            frame_done  = 1'b1;
        end
        pending_pixels = {pending_pixels, o};
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel beat %h", pixel);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, pixel.red);
                check_field("green", want.green, pixel.green);
                check_field("blue", want.blue, pixel.blue);
                check_field("alpha", want.alpha, pixel.alpha);
                check_field("frame_end", want.frame_end, pixel.frame_end);
                if (want.frame_end)
                    frames_done++;
            end
        end
    end

    always @(negedge clk)
        pixel_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 50000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // caller is at a falling edge; returns at a falling edge with valid still high
    task automatic send_beat(logic kind, logic [31:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample.kind = kind;
        sample.raw_sample = raw;
        do
            @(posedge clk);
        while (sample_stall);
        demosaic_step(sample);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        // let zero-result beats settle in the pipeline
        repeat (16) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_W-1:0];
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:    sh_width   = value & 13'h1FFF;
            REG_FRAME_HEIGHT:   sh_height  = value & 13'h1FFF;
            REG_MOSAIC_PATTERN: sh_pattern = value & 3'h7;
            default:            sh_bits    = value & 6'h3F;
        endcase
        in_col    = 0;
        in_row    = 0;
        pix_count = 0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic setup(int unsigned w, int unsigned h, int unsigned pat, int unsigned bits);
        drain();
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_write(REG_MOSAIC_PATTERN, pat);
        cfg_write(REG_SAMPLE_BITS, bits);
    endtask

    function automatic logic [31:0] pick_raw();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // well-formed frame with stray pad ticks, mixed flush, and trailing noise
    task automatic stream_frame(bit noisy);
        int unsigned n;
        n = clamp_dim(sh_width) * clamp_dim(sh_height);
        frame_done = 1'b0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_beat(1'b1, $urandom);
            send_beat(1'b0, pick_raw());
        end
        while (!frame_done)
            send_beat(1'($urandom_range(1)), $urandom);
        if (noisy && $urandom_range(3) == 0)
            send_beat(1'b1, $urandom);
    endtask

    task automatic test_directed();
        logic [31:0] vals [12];
        vals = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0000_0001, 32'hFF00_0000,
                 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        setup(4, 3, PAT_RGGB, 32);
        frame_done = 1'b0;
        for (int i = 0; i < 12; i++)
        begin
            if (i == 5)
                send_beat(1'b1, 32'hFFFF_FFFF);   // pad tick mid-frame is ignored
            send_beat(1'b0, vals[i]);
        end
        send_beat(1'b0, 32'h1234_5678);           // raw beat during flush acts as pad
        while (!frame_done)
            send_beat(1'b1, 32'h0);
        send_beat(1'b1, 32'h0);                   // extra pad after frame end
        setup(1, 1, PAT_GBRG, 1);
        stream_frame(1'b0);
        setup(0, 0, PAT_GRAY, 0);                 // zero width and height clamp to 1
        stream_frame(1'b0);
    endtask

    task automatic test_scaling_and_codes();
        int unsigned bits_list [8];
        bits_list = '{1, 7, 8, 9, 16, 32, 0, 63};
        for (int i = 0; i < 8; i++)
        begin
            setup($urandom_range(1, 5), $urandom_range(1, 4), i, bits_list[i]);
            stream_frame(1'b1);
        end
    endtask

    task automatic test_abort();
        setup(5, 4, PAT_BGGR, 12);
        for (int i = 0; i < 13; i++)
            send_beat(1'b0, $urandom);
        setup(3, 3, PAT_GRBG, 10);
        stream_frame(1'b0);
    endtask

    task automatic test_wide_row();
        setup(8191, 1, PAT_RGGB, 24);
        for (int i = 0; i < 40; i++)
            send_beat(1'b0, $urandom);
        setup(64, 2, PAT_GBRG, 8);
        stream_frame(1'b0);
    endtask

    task automatic test_random(int idle, int stall, int quota);
        int start;
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = beats_sent;
        while (beats_sent - start < quota)
        begin
            setup($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(7),
                  $urandom_range(1, 32));
            stream_frame(1'b1);
        end
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_a[i] = '0;
            row_b[i] = '0;
        end
        evicted = '{8'd0, 8'd0, 8'd0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_scaling_and_codes();
        test_abort();
        test_wide_row();
        test_random(0, 0, 130);
        test_random(71, 0, 130);
        test_random(0, 71, 130);
        test_random(13, 13, 130);
        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d input beats, %0d pixels, %0d complete frames", beats_sent,
                 pixels_seen, frames_done);
        $display("all patterns and undefined codes, sample widths 0..63, clamped sizes");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
